FILE: rtl/tsvmc_pkg.sv
`default_nettype none

package tsvmc_pkg;

    localparam int COL_W        = 9;
    localparam int ROW_W        = 8;
    localparam int RESULT_LIMIT = 64;
    localparam int CNT_W        = 7;

    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_SHOW  = 3'd1;
    localparam logic [2:0] ACT_HIDE  = 3'd2;
    localparam logic [2:0] ACT_TEST  = 3'd3;
    localparam logic [2:0] ACT_CLIP  = 3'd4;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    typedef struct packed {
        logic load;
        logic clr_write;
        logic rect_write;
        logic rect_next;
        logic scan_step;
        logic test_capture;
        logic push_single;
        logic push_final;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       clr_last;
        logic       rect_empty;
        logic       span_empty;
        logic       byte_last;
        logic       row_last;
        logic       found;
        logic       in_run;
        logic       limit;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: rtl/tsvmc_ram.sv
`default_nettype none

module tsvmc_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_addr,
    input  wire logic [WIDTH-1:0]     i_wr_data,
    input  wire logic [AW-1:0]        i_rd_addr,
    output logic      [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/tsvmc_ctrl.sv
`default_nettype none

module tsvmc_ctrl
    import tsvmc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DECODE    = 4'd2;
    localparam logic [3:0] S_RECT_RD   = 4'd3;
    localparam logic [3:0] S_RECT_WR   = 4'd4;
    localparam logic [3:0] S_TEST_RD   = 4'd5;
    localparam logic [3:0] S_TEST_CHK  = 4'd6;
    localparam logic [3:0] S_CLIP_RD   = 4'd7;
    localparam logic [3:0] S_CLIP_SCAN = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_clr_cmd, n_clr_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cmd <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cmd <= n_clr_cmd;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_cmd  = r_clr_cmd;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_stat.clr_last) begin
                    n_state   = r_clr_cmd ? S_DONE : S_IDLE;
                    n_clr_cmd = 1'b0;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.action)
                    ACT_CLEAR: begin
                        n_clr_cmd = 1'b1;
                        n_state   = S_CLEAR;
                    end
                    ACT_SHOW, ACT_HIDE: n_state = i_stat.rect_empty ? S_DONE : S_RECT_RD;
                    ACT_TEST:           n_state = S_TEST_RD;
                    ACT_CLIP:           n_state = i_stat.span_empty ? S_FINISH : S_CLIP_RD;
                    default:            n_state = S_DONE;
                endcase
            end
            S_RECT_RD: n_state = S_RECT_WR;
            S_RECT_WR: begin
                o_cmd.rect_write = 1'b1;
                o_cmd.rect_next  = 1'b1;
                n_state = (i_stat.byte_last && i_stat.row_last) ? S_DONE : S_RECT_RD;
            end
            S_TEST_RD: n_state = S_TEST_CHK;
            S_TEST_CHK: begin
                o_cmd.test_capture = 1'b1;
                n_state = S_DONE;
            end
            S_CLIP_RD: n_state = S_CLIP_SCAN;
            S_CLIP_SCAN: begin
                if (i_stat.out_free) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.found) begin
                        if (i_stat.in_run && i_stat.limit) begin
                            n_state = S_FINISH;
                        end
                    end else begin
                        n_state = i_stat.byte_last ? S_FINISH : S_CLIP_RD;
                    end
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.push_final = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.push_single = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/tsvmc_dp.sv
`default_nettype none

module tsvmc_dp
    import tsvmc_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic [30:0] i_in_data,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [15:0]      o_out_data,
    output logic             o_out_last
);

    localparam int ROW_BYTES = (MAX_COLUMNS + 7) / 8;
    localparam int DEPTH     = ROW_BYTES * MAX_ROWS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW        = COL_W - 3;

    // configuration
    logic [7:0] r_screen_columns;
    logic [6:0] r_screen_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_columns <= 8'd80;
            r_screen_rows    <= 7'd25;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_COLUMNS: r_screen_columns <= i_cfg_data;
                CFG_ROWS:    r_screen_rows    <= i_cfg_data[6:0];
                default:     r_screen_rows    <= r_screen_rows;
            endcase
        end
    end

    // request decode
    logic [2:0]       in_action;
    logic [6:0]       in_column;
    logic [5:0]       in_row;
    logic [7:0]       in_width;
    logic [6:0]       in_height;
    logic [COL_W-1:0] cols_use, col_sum, c_end;
    logic [ROW_W-1:0] rows_use, row_sum, r_end;
    logic             row_ok, col_lt;

    assign in_action = i_in_data[2:0];
    assign in_column = i_in_data[9:3];
    assign in_row    = i_in_data[15:10];
    assign in_width  = i_in_data[23:16];
    assign in_height = i_in_data[30:24];

    assign cols_use = (COL_W'(r_screen_columns) > COL_W'(MAX_COLUMNS)) ?
                      COL_W'(MAX_COLUMNS) : COL_W'(r_screen_columns);
    assign rows_use = (ROW_W'(r_screen_rows) > ROW_W'(MAX_ROWS)) ?
                      ROW_W'(MAX_ROWS) : ROW_W'(r_screen_rows);
    assign col_sum  = COL_W'(in_column) + COL_W'(in_width);
    assign row_sum  = ROW_W'(in_row) + ROW_W'(in_height);
    assign c_end    = (col_sum < cols_use) ? col_sum : cols_use;
    assign r_end    = (row_sum < rows_use) ? row_sum : rows_use;
    assign row_ok   = ROW_W'(in_row) < rows_use;
    assign col_lt   = COL_W'(in_column) < c_end;

    logic [2:0]       r_action;
    logic [6:0]       r_column;
    logic [COL_W-1:0] r_c_end;
    logic [ROW_W-1:0] r_r_end;
    logic             r_rect_empty, r_span_empty, r_test_on, r_test_vis;
    logic [ROW_W-1:0] r_cur_row;
    logic [BW-1:0]    r_byte;
    logic [2:0]       r_pos;
    logic             r_in_run, r_pend_valid;
    logic [COL_W-1:0] r_run_start, r_pend_col;
    logic [7:0]       r_pend_len;
    logic [CNT_W-1:0] r_count;
    logic [AW-1:0]    r_clr_addr;

    // mask memory
    logic [AW-1:0] cell_addr, wr_addr;
    logic [7:0]    ram_q, wr_data, span_mask, vis, cand;
    logic          wr_en;

    assign cell_addr = AW'(32'(r_cur_row) * ROW_BYTES + 32'(r_byte));
    assign wr_en     = i_cmd.clr_write | i_cmd.rect_write;
    assign wr_addr   = i_cmd.clr_write ? r_clr_addr : cell_addr;
    assign wr_data   = i_cmd.clr_write ? 8'd0 :
                       (r_action == ACT_SHOW) ? (ram_q | span_mask) : (ram_q & ~span_mask);

    tsvmc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_mask_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (cell_addr),
        .o_rd_data (ram_q)
    );

    // cells of the current byte inside [column, c_end)
    logic [COL_W-1:0] c_end_m1;
    logic [BW-1:0]    first_byte, last_byte;
    logic             byte_last;

    assign c_end_m1   = r_c_end - COL_W'(1);
    assign first_byte = BW'(r_column[6:3]);
    assign last_byte  = c_end_m1[COL_W-1:3];
    assign byte_last  = r_byte == last_byte;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            span_mask[j] = ({r_byte, 3'(j)} >= COL_W'(r_column)) &&
                           ({r_byte, 3'(j)} < r_c_end);
        end
    end

    assign vis = ram_q & span_mask;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            cand[j] = (3'(j) >= r_pos) && (r_in_run ? !vis[j] : vis[j]);
        end
    end

    logic       found;
    logic [2:0] q_idx;

    always_comb begin
        found = 1'b0;
        q_idx = 3'd0;
        for (int j = 7; j >= 0; j--) begin
            if (cand[j]) begin
                found = 1'b1;
                q_idx = 3'(j);
            end
        end
    end

    logic [COL_W-1:0] end_pos;
    logic [7:0]       run_len;
    logic             complete, limit, scan_push, push_any, out_free;

    assign end_pos   = found ? {r_byte, q_idx} : ({r_byte, 3'b000} + COL_W'(8));
    assign run_len   = 8'(end_pos - r_run_start);
    assign complete  = r_in_run && (found || byte_last);
    assign limit     = r_count == CNT_W'(RESULT_LIMIT - 1);
    assign scan_push = i_cmd.scan_step && complete && r_pend_valid;
    assign push_any  = scan_push | i_cmd.push_single | i_cmd.push_final;
    assign out_free  = !o_out_valid || i_out_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_write) begin
                r_clr_addr <= (r_clr_addr == AW'(DEPTH - 1)) ? '0 : r_clr_addr + AW'(1);
            end
            if (push_any) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // request and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action     <= in_action;
            r_column     <= in_column;
            r_c_end      <= c_end;
            r_r_end      <= r_end;
            r_rect_empty <= !col_lt || !(ROW_W'(in_row) < r_end);
            r_span_empty <= !col_lt || !row_ok;
            r_test_on    <= row_ok && (COL_W'(in_column) < cols_use);
            r_test_vis   <= 1'b0;
            r_cur_row    <= ROW_W'(in_row);
            r_byte       <= BW'(in_column[6:3]);
            r_pos        <= 3'd0;
            r_in_run     <= 1'b0;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
        end
        if (i_cmd.test_capture) begin
            r_test_vis <= r_test_on && ram_q[r_column[2:0]];
        end
        if (i_cmd.rect_next) begin
            if (byte_last) begin
                r_byte    <= first_byte;
                r_cur_row <= r_cur_row + ROW_W'(1);
            end else begin
                r_byte <= r_byte + BW'(1);
            end
        end
        if (i_cmd.scan_step) begin
            if (complete) begin
                r_pend_col   <= r_run_start;
                r_pend_len   <= run_len;
                r_pend_valid <= 1'b1;
                r_count      <= r_count + CNT_W'(1);
                r_in_run     <= 1'b0;
            end
            if (found && !r_in_run) begin
                r_in_run    <= 1'b1;
                r_run_start <= {r_byte, q_idx};
            end
            if (found) begin
                r_pos <= q_idx;
            end else begin
                r_pos  <= 3'd0;
                r_byte <= r_byte + BW'(1);
            end
        end
    end

    // result register: run_column, run_length, cell_visible
    always_ff @(posedge i_clk) begin
        if (scan_push) begin
            o_out_data <= {1'b0, r_pend_len, r_pend_col[6:0]};
            o_out_last <= 1'b0;
        end else if (i_cmd.push_final) begin
            o_out_data <= r_pend_valid ? {1'b0, r_pend_len, r_pend_col[6:0]} :
                                         {1'b0, 8'd0, r_column};
            o_out_last <= 1'b1;
        end else if (i_cmd.push_single) begin
            o_out_data <= {r_test_vis, 8'd0, 7'd0};
            o_out_last <= 1'b1;
        end
    end

    assign o_stat.action     = r_action;
    assign o_stat.clr_last   = r_clr_addr == AW'(DEPTH - 1);
    assign o_stat.rect_empty = r_rect_empty;
    assign o_stat.span_empty = r_span_empty;
    assign o_stat.byte_last  = byte_last;
    assign o_stat.row_last   = (r_cur_row + ROW_W'(1)) == r_r_end;
    assign o_stat.found      = found;
    assign o_stat.in_run     = r_in_run;
    assign o_stat.limit      = limit;
    assign o_stat.out_free   = out_free;

endmodule

`default_nettype wire

FILE: rtl/text_screen_visibility_mask_clipper_core.sv
`default_nettype none

// channel   dir  tdata (lsb up)                                   tlast
// s_axis    in   action[2:0] column[9:3] row[15:10] width[23:16]  -
//                height[30:24], bit 31 zero
// m_axis    out  run_column[6:0] run_length[14:7] cell_visible[15] last
// cfg       in   index 0 screen_columns, 1 screen_rows            -
//
// One request at a time. After reset a clearing pass writes every mask byte,
// (MAX_COLUMNS+7)/8 * MAX_ROWS bytes (1024 at defaults); clear requests rerun it.
// Rectangle: every mask byte of the span in each row is read, then written back;
// test: one mask byte is read and its cell checked. Clip: each mask byte is read,
// then scanned one run edge per step; the mask RAM read is registered.
// Results wait in one output register; a stalled m_axis holds the controller
// at its next result push (clip scan steps and the final or single result).

module text_screen_visibility_mask_clipper_core
    import tsvmc_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // action, column, row, width, height
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // run_column, run_length, cell_visible
    output logic             m_axis_tlast
);

    t_cmd  cmd;
    t_stat stat;

    tsvmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tsvmc_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata[30:0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !s_axis_tready)
        else $error("request taken during clearing pass");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request taken while busy");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.push_single || cmd.push_final || cmd.scan_step) |-> stat.out_free)
        else $error("result pushed into occupied output register");

endmodule

`default_nettype wire
